FILE: rtl/tkls_pkg.sv
// ----------------------------------------------------------------------------
// tkls_pkg
// shared types and field widths of the top-k logit selector
// ----------------------------------------------------------------------------
`default_nettype none

package tkls_pkg;

  localparam int unsigned LP_W    = 32;  // log-probability, signed q16.16
  localparam int unsigned TOKEN_W = 18;  // token position within a row
  localparam int unsigned K_W     = 7;   // k register width

  localparam logic [K_W-1:0] K_COUNT_RESET = 7'd64;

  typedef logic signed [LP_W-1:0] lp_t;
  typedef logic [TOKEN_W-1:0]     tok_t;

  // hand-over of a finished row from the sorter to the emitter
  typedef struct packed {
    logic           load;
    logic [K_W-1:0] count;
  } handoff_t;

endpackage

`default_nettype wire

FILE: rtl/topk_logit_select_core.sv
// ----------------------------------------------------------------------------
// topk_logit_select_core
// streaming top-k selector over rows of q16.16 logits
// ----------------------------------------------------------------------------
// One logit is taken per clock: it passes an input register where the row's
// log normaliser is subtracted with saturation, then enters a sorted array of
// MAX_K entries, where every slot compares the new value in
// parallel and the array shifts to make room. The k best entries of the row
// are thus always held in emission order (highest first, earlier position on
// ties). On the beat marked tlast the array is copied whole into a result
// buffer and cleared, so the next row streams in at one item per cycle while
// the buffer drains one result per cycle on the master side. The only stall
// on the slave side comes from the buffer: an end-of-row beat waits while the
// previous row still has results to deliver, which takes longer under master
// back-pressure. Row positions count inside the block and stop at MAX_VOCAB;
// later items of the row are ignored except that their tlast still ends the
// row.
// ----------------------------------------------------------------------------
`default_nettype none

module topk_logit_select_core #(
  parameter int unsigned MAX_K     = 64,
  parameter int unsigned MAX_VOCAB = 262144
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: k_count
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [31:0] logit, [63:32] row_log_norm
  input  wire logic        s_axis_tlast,   // last_in_row
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [55:0] m_axis_tdata,   // [17:0] token_index, [49:18] log_prob, rest 0
  output      logic        m_axis_tlast    // last_result
);

  logic [tkls_pkg::K_W-1:0] k_count;

  logic                in_beat;
  logic                f_valid;
  tkls_pkg::lp_t       f_lp;
  logic                f_last;
  logic                step;
  logic                emit_free;

  tkls_pkg::lp_t       row_val [MAX_K];
  tkls_pkg::tok_t      row_idx [MAX_K];
  tkls_pkg::handoff_t  handoff;

  tkls_pkg::lp_t       out_lp;
  tkls_pkg::tok_t      out_idx;

  // k register; the user must write it only while the block is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= tkls_pkg::K_COUNT_RESET;
    end else if (cfg_wr_en) begin
      k_count <= cfg_wr_data;
    end
  end

  // an item leaves the input register unless it ends a row and the result
  // buffer is still busy with the previous one
  assign step          = f_valid && (!f_last || emit_free);
  assign s_axis_tready = !f_valid || step;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  tkls_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_beat      (in_beat),
    .logit        (s_axis_tdata[31:0]),
    .row_log_norm (s_axis_tdata[63:32]),
    .last_in_row  (s_axis_tlast),
    .pop          (step),
    .valid        (f_valid),
    .lp           (f_lp),
    .last         (f_last)
  );

  tkls_sorter #(
    .MAX_K     (MAX_K),
    .MAX_VOCAB (MAX_VOCAB)
  ) u_sorter (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .lp      (f_lp),
    .last    (f_last),
    .k_count (k_count),
    .row_val (row_val),
    .row_idx (row_idx),
    .handoff (handoff)
  );

  tkls_emitter #(
    .MAX_K (MAX_K)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .handoff   (handoff),
    .row_val   (row_val),
    .row_idx   (row_idx),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_lp    (out_lp),
    .out_idx   (out_idx),
    .out_last  (m_axis_tlast),
    .free      (emit_free)
  );

  assign m_axis_tdata = {6'd0, out_lp, out_idx};

  a_no_stall_mid_row: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_last) |-> step)
    else $error("input stalled on an item that does not end a row");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !step) |=> (f_valid && $stable(f_lp) && f_last))
    else $error("stalled end-of-row item lost its contents");

  a_result_follows_row: assert property (@(posedge clk) disable iff (rst)
    handoff.load |=> m_axis_tvalid)
    else $error("end of row produced no result");

endmodule

`default_nettype wire

FILE: rtl/tkls_front.sv
// ----------------------------------------------------------------------------
// tkls_front
// input register: saturating logit minus normaliser and end-of-row flag
// ----------------------------------------------------------------------------
`default_nettype none

module tkls_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_beat,
  input  wire tkls_pkg::lp_t       logit,
  input  wire tkls_pkg::lp_t       row_log_norm,
  input  wire logic                last_in_row,
  input  wire logic                pop,
  output      logic                valid,
  output      tkls_pkg::lp_t       lp,
  output      logic                last
);

  logic signed [tkls_pkg::LP_W:0] diff;
  tkls_pkg::lp_t                  lp_next;

  always_comb begin
    diff = {logit[tkls_pkg::LP_W-1], logit} - {row_log_norm[tkls_pkg::LP_W-1], row_log_norm};
    if (diff[tkls_pkg::LP_W] != diff[tkls_pkg::LP_W-1]) begin
      // overflow: clamp towards the sign of the true difference
      lp_next = diff[tkls_pkg::LP_W] ? {1'b1, {(tkls_pkg::LP_W-1){1'b0}}}
                                     : {1'b0, {(tkls_pkg::LP_W-1){1'b1}}};
    end else begin
      lp_next = diff[tkls_pkg::LP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_beat) begin
      valid <= 1'b1;
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      lp   <= lp_next;
      last <= last_in_row;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tkls_sorter.sv
// ----------------------------------------------------------------------------
// tkls_sorter
// sorted insertion array holding the best entries of the current row
// ----------------------------------------------------------------------------
`default_nettype none

module tkls_sorter #(
  parameter int unsigned MAX_K     = 64,
  parameter int unsigned MAX_VOCAB = 262144
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire tkls_pkg::lp_t          lp,
  input  wire logic                   last,
  input  wire logic [tkls_pkg::K_W-1:0] k_count,
  output      tkls_pkg::lp_t          row_val [MAX_K],
  output      tkls_pkg::tok_t         row_idx [MAX_K],
  output      tkls_pkg::handoff_t     handoff
);

  localparam int unsigned FW = $clog2(MAX_K + 1);
  localparam int unsigned EW = $clog2(MAX_VOCAB + 1);

  tkls_pkg::lp_t  val [MAX_K];
  tkls_pkg::tok_t idx [MAX_K];
  logic [FW-1:0]  fill;
  logic [FW-1:0]  fill_next;
  logic [EW-1:0]  element_index;
  logic [FW-1:0]  k_eff;
  logic [MAX_K-1:0] outranks;
  logic [MAX_K-1:0] occupied;
  logic           in_range;
  logic           append;
  logic           replace;
  logic           insert_en;
  tkls_pkg::tok_t new_idx;

  // k of zero acts as one, anything above the array depth as the depth
  always_comb begin
    if (k_count == '0) begin
      k_eff = FW'(1);
    end else if (k_count > tkls_pkg::K_W'(MAX_K)) begin
      k_eff = FW'(MAX_K);
    end else begin
      k_eff = FW'(k_count);
    end
  end

  // new entry carries the highest position so far, so on equal values it
  // ranks after the kept one; free slots always rank after it
  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      occupied[j] = (FW'(j) < fill);
      outranks[j] = !occupied[j] || (lp > val[j]);
    end
  end

  assign in_range  = (element_index < EW'(MAX_VOCAB));
  assign new_idx   = tkls_pkg::TOKEN_W'(element_index);
  assign append    = (fill < k_eff) && (fill < FW'(MAX_K));
  // sorted array: beating the weakest kept entry is beating any kept entry
  assign replace   = |(outranks & occupied);
  assign insert_en = step && in_range && (append || replace);
  assign fill_next = (insert_en && append) ? fill + FW'(1) : fill;

  always_comb begin
    for (int j = 0; j < MAX_K; j++) begin
      row_val[j] = val[j];
      row_idx[j] = idx[j];
      if (insert_en) begin
        if (j > 0 && outranks[(j > 0) ? j - 1 : 0]) begin
          row_val[j] = val[(j > 0) ? j - 1 : 0];
          row_idx[j] = idx[(j > 0) ? j - 1 : 0];
        end else if (outranks[j]) begin
          row_val[j] = lp;
          row_idx[j] = new_idx;
        end
      end
    end
  end

  always_comb begin
    handoff.load  = step && last;
    handoff.count = tkls_pkg::K_W'((fill_next < k_eff) ? fill_next : k_eff);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_K; j++) begin
      val[j] <= row_val[j];
      idx[j] <= row_idx[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      element_index <= '0;
    end else if (step && last) begin
      fill          <= '0;
      element_index <= '0;
    end else if (step) begin
      fill <= fill_next;
      if (in_range) begin
        element_index <= element_index + EW'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_K))
    else $error("fill count beyond array depth");

  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (fill == '0 && element_index == '0))
    else $error("row state not cleared after end of row");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    element_index <= EW'(MAX_VOCAB))
    else $error("element index past vocabulary bound");

endmodule

`default_nettype wire

FILE: rtl/tkls_emitter.sv
// ----------------------------------------------------------------------------
// tkls_emitter
// result buffer that drains a finished row one entry per beat
// ----------------------------------------------------------------------------
`default_nettype none

module tkls_emitter #(
  parameter int unsigned MAX_K = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tkls_pkg::handoff_t   handoff,
  input  wire tkls_pkg::lp_t        row_val [MAX_K],
  input  wire tkls_pkg::tok_t       row_idx [MAX_K],
  input  wire logic                 out_ready,
  output      logic                 out_valid,
  output      tkls_pkg::lp_t        out_lp,
  output      tkls_pkg::tok_t       out_idx,
  output      logic                 out_last,
  output      logic                 free
);

  localparam int unsigned FW = $clog2(MAX_K + 1);

  tkls_pkg::lp_t  val [MAX_K];
  tkls_pkg::tok_t idx [MAX_K];
  logic [FW-1:0]  cnt;
  logic           beat;

  assign out_valid = (cnt != '0);
  assign beat      = out_valid && out_ready;
  assign out_last  = (cnt == FW'(1));
  assign out_lp    = val[0];
  assign out_idx   = idx[0];
  // free now, or about to be once the final entry goes out
  assign free      = (cnt == '0) || (out_last && beat);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (handoff.load) begin
      cnt <= FW'(handoff.count);
    end else if (beat) begin
      cnt <= cnt - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (handoff.load) begin
      for (int j = 0; j < MAX_K; j++) begin
        val[j] <= row_val[j];
        idx[j] <= row_idx[j];
      end
    end else if (beat) begin
      for (int j = 0; j < MAX_K - 1; j++) begin
        val[j] <= val[j+1];
        idx[j] <= idx[j+1];
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    handoff.load |-> free)
    else $error("row handed over while previous row still draining");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FW'(MAX_K))
    else $error("emit count beyond buffer depth");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (beat && !handoff.load) |=> (cnt == $past(cnt) - FW'(1)))
    else $error("emit count did not step down on a beat");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming top-k logit selector
// ----------------------------------------------------------------------------
// Rows of q16.16 logits are streamed into the slave side with random gaps
// while the master side stalls at random. Every accepted input beat is run
// through a behavioural copy of the selector kept here, and the ranked
// entries it predicts at each end of row are checked, field by field and in
// order, against the result beats. The run covers saturation at both ends,
// ties, k settings from zero to the top of the register, and k lowered in
// the middle of a row.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned MAX_K     = 64;
  localparam int unsigned MAX_VOCAB = 262144;
  localparam int unsigned SETTLE    = 16;    // cycles for the pipe to empty
  localparam int unsigned WATCHDOG  = 1000;  // cycles with no beat on either side
  localparam int unsigned SEG_ITEMS = 14;    // minimum input beats per random segment

  localparam tkls_pkg::lp_t LP_MAX = 32'sh7fff_ffff;
  localparam tkls_pkg::lp_t LP_MIN = 32'sh8000_0000;
  localparam tkls_pkg::lp_t ONE    = 32'sh0001_0000;

  // one slave-side beat as queued by the stimulus
  typedef struct {
    tkls_pkg::lp_t logit;
    tkls_pkg::lp_t norm;
    logic          last;
    int unsigned   gap;  // idle cycles before the beat is offered
  } logit_beat_t;

  // one ranked entry as expected on the master side
  typedef struct packed {
    tkls_pkg::tok_t token;
    tkls_pkg::lp_t  lp;
    logic           last;
  } ranked_entry_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [tkls_pkg::K_W-1:0]   cfg_wr_data = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [63:0]                s_axis_tdata = '0;
  logic                       s_axis_tlast = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [55:0]                m_axis_tdata;
  logic                       m_axis_tlast;

  topk_logit_select_core #(
    .MAX_K     (MAX_K),
    .MAX_VOCAB (MAX_VOCAB)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // behavioural copy of the selector state
  // --------------------------------------------------------------------------
  tkls_pkg::lp_t            kept_lp  [MAX_K];
  tkls_pkg::tok_t           kept_tok [MAX_K];
  int unsigned              kept_fill = 0;
  int unsigned              row_pos   = 0;
  logic [tkls_pkg::K_W-1:0] k_setting = tkls_pkg::K_COUNT_RESET;

  logit_beat_t   logit_queue[$];      // beats waiting to be driven
  ranked_entry_t ranked_expected[$];  // entries still owed by the block

  int unsigned beats_in  = 0;
  int unsigned rows_in   = 0;
  int unsigned beats_out = 0;
  int unsigned errors    = 0;

  bit calm       = 1'b0;  // no gaps on the slave side
  bit stall_free = 1'b0;  // no back-pressure on the master side

  // take one accepted beat through the selector and queue what it emits
  function automatic void rank_logit(logit_beat_t b);
    logic signed [tkls_pkg::LP_W:0] diff;
    tkls_pkg::lp_t                  lp;
    tkls_pkg::lp_t                  v [MAX_K];
    tkls_pkg::tok_t                 t [MAX_K];
    tkls_pkg::lp_t                  tv;
    tkls_pkg::tok_t                 tt;
    ranked_entry_t                  r;
    int unsigned                    k, victim, best, n, emit;

    diff = $signed({b.logit[tkls_pkg::LP_W-1], b.logit})
         - $signed({b.norm[tkls_pkg::LP_W-1], b.norm});
    // out of range when the two top bits disagree
    if (diff[tkls_pkg::LP_W] != diff[tkls_pkg::LP_W-1]) begin
      lp = diff[tkls_pkg::LP_W] ? LP_MIN : LP_MAX;
    end else begin
      lp = diff[tkls_pkg::LP_W-1:0];
    end

    // zero acts as one, anything above the array size as the array size
    k = k_setting;
    if (k == 0) begin
      k = 1;
    end
    if (k > MAX_K) begin
      k = MAX_K;
    end

    // positions past the vocabulary bound are dropped
    if (row_pos < MAX_VOCAB) begin
      if (kept_fill < k && kept_fill < MAX_K) begin
        kept_lp[kept_fill]  = lp;
        kept_tok[kept_fill] = tkls_pkg::tok_t'(row_pos);
        kept_fill++;
      end else if (kept_fill != 0) begin
        // evict the smallest, the latest position among equal smallest
        victim = 0;
        for (int j = 1; j < kept_fill; j++) begin
          if (kept_lp[j] < kept_lp[victim] ||
              (kept_lp[j] == kept_lp[victim] && kept_tok[j] > kept_tok[victim])) begin
            victim = j;
          end
        end
        if (lp > kept_lp[victim]) begin
          kept_lp[victim]  = lp;
          kept_tok[victim] = tkls_pkg::tok_t'(row_pos);
        end
      end
      row_pos++;
    end

    if (!b.last) begin
      return;
    end

    // rank highest first, earlier position first on ties
    n = kept_fill;
    v = kept_lp;
    t = kept_tok;
    for (int i = 0; i < n; i++) begin
      best = i;
      for (int j = i + 1; j < n; j++) begin
        if (v[j] > v[best] || (v[j] == v[best] && t[j] < t[best])) begin
          best = j;
        end
      end
      tv = v[i];
      tt = t[i];
      v[i] = v[best];
      t[i] = t[best];
      v[best] = tv;
      t[best] = tt;
    end
    // a lowered k mid-row trims the emission only
    emit = (n < k) ? n : k;
    for (int i = 0; i < emit; i++) begin
      r.token = t[i];
      r.lp    = v[i];
      r.last  = (i + 1 == emit);
      ranked_expected.insert(ranked_expected.size(), r);
    end
    kept_fill = 0;
    row_pos   = 0;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) begin
      return 0;
    end else if (p < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // logit or normaliser: extremes, full range, tie-prone steps, moderate values
  function automatic tkls_pkg::lp_t rand_q();
    case ($urandom_range(0, 9))
      0: begin
        return $urandom_range(0, 1) ? LP_MAX : LP_MIN;
      end
      1, 2, 3: begin
        return tkls_pkg::lp_t'($urandom);
      end
      4, 5, 6: begin
        return tkls_pkg::lp_t'((int'($urandom_range(0, 8)) - 4) * 65536);
      end
      default: begin
        return tkls_pkg::lp_t'(int'($urandom_range(0, 40 * 65536)) - 20 * 65536);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // slave-side driver
  // --------------------------------------------------------------------------
  logit_beat_t beat_now;
  int unsigned gap_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_count = 0;
    end else begin
      // the beat offered up to now has just been taken
      if (s_axis_tvalid && s_axis_tready) begin
        rank_logit(beat_now);
        beats_in++;
        if (beat_now.last) begin
          rows_in++;
        end
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the beat until it is taken
      end else if (logit_queue.size() != 0 && gap_count >= logit_queue[0].gap) begin
        beat_now = logit_queue.pop_front();
        gap_count = 0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {beat_now.norm, beat_now.logit};
        s_axis_tlast  <= beat_now.last;
      end else begin
        if (logit_queue.size() != 0) begin
          gap_count++;
        end
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // master-side back-pressure
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!stall_free && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // master-side monitor
  // --------------------------------------------------------------------------
  ranked_entry_t got_entry;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (ranked_expected.size() == 0) begin
        $error("unexpected result beat: token_index %0d log_prob %0d",
               m_axis_tdata[tkls_pkg::TOKEN_W-1:0],
               $signed(m_axis_tdata[tkls_pkg::TOKEN_W+tkls_pkg::LP_W-1:tkls_pkg::TOKEN_W]));
        errors++;
      end else begin
        got_entry = ranked_expected.pop_front();
        if (m_axis_tdata[tkls_pkg::TOKEN_W-1:0] !== got_entry.token) begin
          $error("token_index: expected %0d, actual %0d",
                 got_entry.token, m_axis_tdata[tkls_pkg::TOKEN_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[tkls_pkg::TOKEN_W+tkls_pkg::LP_W-1:tkls_pkg::TOKEN_W]
            !== got_entry.lp) begin
          $error("log_prob: expected %0d, actual %0d", got_entry.lp,
                 $signed(m_axis_tdata[tkls_pkg::TOKEN_W+tkls_pkg::LP_W-1:tkls_pkg::TOKEN_W]));
          errors++;
        end
        if (m_axis_tlast !== got_entry.last) begin
          $error("last_result: expected %0b, actual %0b", got_entry.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without a beat on either side
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG) begin
        $display("timeout: %0d beats still queued, %0d results outstanding",
                 logit_queue.size(), ranked_expected.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // wait until nothing is queued, offered or owed, then let the pipe settle
  task automatic wait_idle(input int unsigned settle);
    do begin
      @(negedge clk);
    end while (logit_queue.size() != 0 || s_axis_tvalid || ranked_expected.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // k may only change with the block idle
  task automatic write_k(input logic [tkls_pkg::K_W-1:0] value);
    wait_idle(SETTLE);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    k_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_beat(input tkls_pkg::lp_t logit, input tkls_pkg::lp_t norm,
                           input logic last);
    logit_beat_t b;
    b.logit = logit;
    b.norm  = norm;
    b.last  = last;
    b.gap   = calm ? 0 : pick_gap();
    logit_queue.insert(logit_queue.size(), b);
  endtask

  logic [tkls_pkg::K_W-1:0] k_plan [6];

  initial begin
    int unsigned   made, len, p;
    bit            cut;
    tkls_pkg::lp_t norm, n2;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part, k at its reset value first ----
    // row of one, difference saturates high
    push_beat(LP_MAX, LP_MIN, 1'b1);
    // saturation low, plain value, exact zero
    push_beat(LP_MIN, LP_MAX, 1'b0);
    push_beat(32'sh1234_5678, '0, 1'b0);
    push_beat(-32'sd5, -32'sd5, 1'b1);

    // k of zero keeps one entry; equal values never displace it
    write_k('0);
    for (int i = 0; i < 4; i++) begin
      push_beat(ONE, '0, i == 3);
    end

    // k of two: ties, a value equal to both kept minima displaces neither
    write_k(7'd2);
    push_beat(3 * ONE, '0, 1'b0);
    push_beat(5 * ONE, '0, 1'b0);
    push_beat(5 * ONE, '0, 1'b0);
    push_beat(5 * ONE, '0, 1'b0);
    push_beat(ONE, '0, 1'b1);

    // k above the array size; differences right at both range limits
    write_k(7'd127);
    push_beat(-32'sd1, LP_MAX, 1'b0);
    push_beat(LP_MAX, -32'sd1, 1'b1);

    // k lowered in the middle of a row
    write_k(7'd6);
    for (int i = 0; i < 8; i++) begin
      push_beat(tkls_pkg::lp_t'(int'($urandom_range(0, 3)) * 65536), '0, 1'b0);
    end
    write_k(7'd3);
    push_beat(2 * ONE, '0, 1'b0);
    push_beat(-ONE, '0, 1'b1);

    // ---- random rows, one k setting per segment ----
    k_plan[0] = 7'd64;
    k_plan[1] = 7'd1;
    k_plan[2] = tkls_pkg::K_W'($urandom_range(2, 63));
    k_plan[3] = 7'd64;
    k_plan[4] = tkls_pkg::K_W'($urandom_range(0, 127));
    k_plan[5] = tkls_pkg::K_W'($urandom_range(1, 20));
    for (int seg = 0; seg < 6; seg++) begin
      write_k(k_plan[seg]);
      // one segment runs flat out on both sides
      calm = (seg == 2);
      stall_free = (seg == 2);
      made = 0;
      while (made < SEG_ITEMS) begin
        p = $urandom_range(0, 99);
        if (seg == 3 && made == 0) begin
          len = 70;  // more entries than k can hold
        end else if (p < 70) begin
          len = $urandom_range(1, 12);
        end else if (p < 95) begin
          len = $urandom_range(13, 40);
        end else begin
          len = $urandom_range(41, 90);
        end
        norm = rand_q();
        // now and then a segment stops inside a row and the next one finishes it
        cut = (made + len >= SEG_ITEMS) && (seg < 5) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
          n2 = ($urandom_range(0, 19) == 0) ? rand_q() : norm;
          push_beat(rand_q(), n2, (i == len - 1) && !cut);
        end
        made += len;
      end
    end

    wait_idle(2 * SETTLE);
    $display("%0d input beats in %0d rows, k from zero to the register top, mid-row k change",
             beats_in, rows_in);
    $display("%0d result beats checked, saturation and ties on both sides", beats_out);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tkls_pkg.sv
rtl/tkls_front.sv
rtl/tkls_sorter.sv
rtl/tkls_emitter.sv
rtl/topk_logit_select_core.sv
bench/testbench.sv
